/* sv/npsc_pkg.sv */
// Shared constants, codes and types of the nearest point search core.
`timescale 1ns / 1ps
`default_nettype none

package npsc_pkg;

   localparam int LEAF_POINTS = 16;
   localparam int COORD_BITS  = 16;
   localparam int TAG_BITS    = 16;

   localparam int OP_BITS     = 3;
   localparam int STATUS_BITS = 2;
   localparam int RADIUS_BITS = COORD_BITS + 1;
   localparam int IDX_BITS    = (LEAF_POINTS > 1) ? $clog2(LEAF_POINTS) : 1;
   localparam int COUNT_BITS  = $clog2(LEAF_POINTS + 1);

   // operand of the shared unit holds a coordinate or the unsigned radius
   localparam int DIFF_BITS   = COORD_BITS + 2;
   localparam int MAG_BITS    = COORD_BITS + 1;
   localparam int DIST_BITS   = 2 * MAG_BITS;

   typedef enum logic [OP_BITS-1:0] {
      OP_CLEAR   = 3'd0,
      OP_LOAD    = 3'd1,
      OP_NEAREST = 3'd2,
      OP_EXCLUDE = 3'd3,
      OP_RADIUS  = 3'd4
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK   = 2'd0,
      ST_NONE = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      TERM_QUERY  = 2'd0,
      TERM_CENTER = 2'd1,
      TERM_RADIUS = 2'd2
   } term_kind_type;

   // sideband that travels with each squared term through the unit
   typedef struct packed {
      logic                first;
      logic                last;
      term_kind_type       kind;
      logic [TAG_BITS-1:0] tag;
   } term_info_type;

endpackage

`default_nettype wire

/* sv/npsc_point_store.sv */
// Register file of stored points: one write port, one read port.
`timescale 1ns / 1ps
`default_nettype none

module npsc_point_store import npsc_pkg::*; (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [IDX_BITS-1:0]          wr_addr,
   input  wire logic signed [COORD_BITS-1:0] wr_x,
   input  wire logic signed [COORD_BITS-1:0] wr_y,
   input  wire logic signed [COORD_BITS-1:0] wr_z,
   input  wire logic [TAG_BITS-1:0]          wr_tag,
   input  wire logic [IDX_BITS-1:0]          rd_addr,
   output logic signed [COORD_BITS-1:0]      rd_x,
   output logic signed [COORD_BITS-1:0]      rd_y,
   output logic signed [COORD_BITS-1:0]      rd_z,
   output logic [TAG_BITS-1:0]               rd_tag
);

   logic signed [COORD_BITS-1:0] x_ff   [LEAF_POINTS];
   logic signed [COORD_BITS-1:0] y_ff   [LEAF_POINTS];
   logic signed [COORD_BITS-1:0] z_ff   [LEAF_POINTS];
   logic [TAG_BITS-1:0]          tag_ff [LEAF_POINTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_ff[wr_addr]   <= wr_x;
         y_ff[wr_addr]   <= wr_y;
         z_ff[wr_addr]   <= wr_z;
         tag_ff[wr_addr] <= wr_tag;
      end
   end

   assign rd_x   = x_ff[rd_addr];
   assign rd_y   = y_ff[rd_addr];
   assign rd_z   = z_ff[rd_addr];
   assign rd_tag = tag_ff[rd_addr];

endmodule

`default_nettype wire

/* sv/npsc_sqdist_unit.sv */
// Shared difference, square and accumulate pipeline: one term per cycle.
`timescale 1ns / 1ps
`default_nettype none

module npsc_sqdist_unit import npsc_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        issue_valid,
   input  wire logic signed [DIFF_BITS-1:0] issue_a,
   input  wire logic signed [DIFF_BITS-1:0] issue_b,
   input  wire term_info_type               issue_info,
   output logic                             busy,
   output logic                             done_valid,
   output term_info_type                    done_info,
   output logic [DIST_BITS-1:0]             done_dist
);

   logic                        v1_ff, v2_ff, v3_ff;
   term_info_type               info1_ff, info2_ff, info3_ff;
   logic signed [DIFF_BITS-1:0] diff_ff;
   logic [DIST_BITS-1:0]        sq_ff;
   logic [DIST_BITS-1:0]        acc_ff;
   logic [DIFF_BITS-1:0]        neg_diff;
   logic [MAG_BITS-1:0]         mag;

   assign neg_diff = DIFF_BITS'(-diff_ff);
   assign mag      = diff_ff[DIFF_BITS-1] ? neg_diff[MAG_BITS-1:0]
                                          : diff_ff[MAG_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= issue_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      info1_ff <= issue_info;
      info2_ff <= info1_ff;
      info3_ff <= info2_ff;
      diff_ff  <= issue_a - issue_b;
      sq_ff    <= DIST_BITS'(mag) * DIST_BITS'(mag);
      // restart the sum on the first term of a distance
      if (v2_ff) begin
         acc_ff <= info2_ff.first ? sq_ff : acc_ff + sq_ff;
      end
   end

   assign busy       = v1_ff | v2_ff | v3_ff;
   assign done_valid = v3_ff & info3_ff.last;
   assign done_info  = info3_ff;
   assign done_dist  = acc_ff;

endmodule

`default_nettype wire

/* sv/nearest_point_search_core.sv */
// Nearest point search core: point store, sequencer and result register.
//
// Input channel req_* (valid/ready) carries one operation per item: clear,
// load one point, nearest search, nearest search skipping one tag, or nearest
// search limited to a radius around a centre. Every item gives exactly one
// result item on rsp_* (valid/ready): status, tag and squared distance.
// req_ready is high only while the sequencer is idle; the result register
// lets a new item be accepted while the previous result still waits.
// Clear, load and unused codes go straight to the result register. After the
// result is loaded, the sequencer returns to idle and accepts the next item.
// Search time is set by the single squarer, which takes one axis term a cycle
// (three per distance, six when the centre distance is also needed); a point
// skipped by tag issues no terms.
// Reset empties the store and drops any pending result. When the receiver
// stalls, the finished result holds in the output register and the block
// stays in its final state until the result register frees.
`timescale 1ns / 1ps
`default_nettype none

module nearest_point_search_core import npsc_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [OP_BITS-1:0]            req_operation,
   input  wire logic signed [COORD_BITS-1:0]  req_coord_x,
   input  wire logic signed [COORD_BITS-1:0]  req_coord_y,
   input  wire logic signed [COORD_BITS-1:0]  req_coord_z,
   input  wire logic [TAG_BITS-1:0]           req_point_index,
   input  wire logic signed [COORD_BITS-1:0]  req_center_x,
   input  wire logic signed [COORD_BITS-1:0]  req_center_y,
   input  wire logic signed [COORD_BITS-1:0]  req_center_z,
   input  wire logic [RADIUS_BITS-1:0]        req_radius,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [STATUS_BITS-1:0]             rsp_status,
   output logic [TAG_BITS-1:0]                rsp_nearest_index,
   output logic [DIST_BITS-1:0]               rsp_nearest_dist_sq
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_DRAIN,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_QX,
      PH_QY,
      PH_QZ,
      PH_CX,
      PH_CY,
      PH_CZ,
      PH_RAD
   } phase_type;

   state_type                    state_ff;
   phase_type                    phase_ff;
   logic [COUNT_BITS-1:0]        count_ff;
   logic [COUNT_BITS-1:0]        k_ff;
   logic [OP_BITS-1:0]           op_ff;
   logic signed [COORD_BITS-1:0] qx_ff, qy_ff, qz_ff;
   logic signed [COORD_BITS-1:0] cx_ff, cy_ff, cz_ff;
   logic [TAG_BITS-1:0]          excl_ff;
   logic [RADIUS_BITS-1:0]       radius_ff;
   logic [DIST_BITS-1:0]         r_sq_ff;
   logic                         center_ok_ff;
   logic                         found_ff;
   logic [DIST_BITS-1:0]         best_dist_ff;
   logic [TAG_BITS-1:0]          best_tag_ff;
   status_type                   status_ff;
   logic                         rsp_valid_ff;
   logic [STATUS_BITS-1:0]       rsp_status_ff;
   logic [TAG_BITS-1:0]          rsp_index_ff;
   logic [DIST_BITS-1:0]         rsp_dist_ff;

   // store ports
   logic                         wr_en;
   logic signed [COORD_BITS-1:0] rd_x, rd_y, rd_z;
   logic [TAG_BITS-1:0]          rd_tag;

   // shared unit ports
   logic                         issue_valid;
   logic signed [DIFF_BITS-1:0]  issue_a, issue_b;
   term_info_type                issue_info;
   logic                         unit_busy;
   logic                         unit_done;
   term_info_type                unit_info;
   logic [DIST_BITS-1:0]         unit_dist;

   // sequencer next values
   phase_type                    phase_in;
   logic [COUNT_BITS-1:0]        k_in;
   logic                         scan_end;
   logic                         is_search;
   logic                         accept;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE);
   assign wr_en     = accept && (req_operation == OP_LOAD) &&
                      (count_ff < COUNT_BITS'(LEAF_POINTS));
   assign is_search = (op_ff == OP_NEAREST) || (op_ff == OP_EXCLUDE) ||
                      (op_ff == OP_RADIUS);

   npsc_point_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_BITS-1:0]),
      .wr_x    (req_coord_x),
      .wr_y    (req_coord_y),
      .wr_z    (req_coord_z),
      .wr_tag  (req_point_index),
      .rd_addr (k_ff[IDX_BITS-1:0]),
      .rd_x    (rd_x),
      .rd_y    (rd_y),
      .rd_z    (rd_z),
      .rd_tag  (rd_tag)
   );

   npsc_sqdist_unit u_unit (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (issue_valid),
      .issue_a     (issue_a),
      .issue_b     (issue_b),
      .issue_info  (issue_info),
      .busy        (unit_busy),
      .done_valid  (unit_done),
      .done_info   (unit_info),
      .done_dist   (unit_dist)
   );

   // pick the next term: for a radius search the radius once, then centre and query axes per point; else query axes
   always_comb begin
      issue_valid      = 1'b0;
      issue_a          = '0;
      issue_b          = '0;
      issue_info.first = 1'b0;
      issue_info.last  = 1'b0;
      issue_info.kind  = TERM_QUERY;
      issue_info.tag   = rd_tag;
      phase_in         = phase_ff;
      k_in             = k_ff;
      scan_end         = 1'b0;
      if (state_ff == S_ISSUE) begin
         if (phase_ff == PH_RAD) begin
            issue_valid      = 1'b1;
            issue_a          = DIFF_BITS'({1'b0, radius_ff});
            issue_info.first = 1'b1;
            issue_info.last  = 1'b1;
            issue_info.kind  = TERM_RADIUS;
            phase_in         = PH_CX;
         end else if (k_ff >= count_ff) begin
            scan_end = 1'b1;
         end else if ((phase_ff == PH_QX) && (op_ff == OP_EXCLUDE) &&
                      (rd_tag == excl_ff)) begin
            // drop this point without a term
            k_in = k_ff + 1'b1;
         end else begin
            issue_valid = 1'b1;
            case (phase_ff)
               PH_QX: begin
                  issue_a          = {{2{rd_x[COORD_BITS-1]}}, rd_x};
                  issue_b          = {{2{qx_ff[COORD_BITS-1]}}, qx_ff};
                  issue_info.first = 1'b1;
                  phase_in         = PH_QY;
               end
               PH_QY: begin
                  issue_a  = {{2{rd_y[COORD_BITS-1]}}, rd_y};
                  issue_b  = {{2{qy_ff[COORD_BITS-1]}}, qy_ff};
                  phase_in = PH_QZ;
               end
               PH_QZ: begin
                  issue_a         = {{2{rd_z[COORD_BITS-1]}}, rd_z};
                  issue_b         = {{2{qz_ff[COORD_BITS-1]}}, qz_ff};
                  issue_info.last = 1'b1;
                  k_in            = k_ff + 1'b1;
                  phase_in        = (op_ff == OP_RADIUS) ? PH_CX : PH_QX;
               end
               PH_CX: begin
                  issue_a          = {{2{rd_x[COORD_BITS-1]}}, rd_x};
                  issue_b          = {{2{cx_ff[COORD_BITS-1]}}, cx_ff};
                  issue_info.first = 1'b1;
                  issue_info.kind  = TERM_CENTER;
                  phase_in         = PH_CY;
               end
               PH_CY: begin
                  issue_a         = {{2{rd_y[COORD_BITS-1]}}, rd_y};
                  issue_b         = {{2{cy_ff[COORD_BITS-1]}}, cy_ff};
                  issue_info.kind = TERM_CENTER;
                  phase_in        = PH_CZ;
               end
               PH_CZ: begin
                  issue_a         = {{2{rd_z[COORD_BITS-1]}}, rd_z};
                  issue_b         = {{2{cz_ff[COORD_BITS-1]}}, cz_ff};
                  issue_info.last = 1'b1;
                  issue_info.kind = TERM_CENTER;
                  phase_in        = PH_QX;
               end
               default: begin
                  issue_valid = 1'b0;
                  phase_in    = PH_QX;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the done state loads the next result itself
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         if (unit_done) begin
            case (unit_info.kind)
               TERM_RADIUS: r_sq_ff      <= unit_dist;
               TERM_CENTER: center_ok_ff <= (unit_dist <= r_sq_ff);
               TERM_QUERY: begin
                  // strict less keeps the earliest point on a tie
                  if (center_ok_ff && (!found_ff || (unit_dist < best_dist_ff))) begin
                     found_ff     <= 1'b1;
                     best_dist_ff <= unit_dist;
                     best_tag_ff  <= unit_info.tag;
                  end
               end
               default: ;
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff        <= req_operation;
                  qx_ff        <= req_coord_x;
                  qy_ff        <= req_coord_y;
                  qz_ff        <= req_coord_z;
                  cx_ff        <= req_center_x;
                  cy_ff        <= req_center_y;
                  cz_ff        <= req_center_z;
                  excl_ff      <= req_point_index;
                  radius_ff    <= req_radius;
                  found_ff     <= 1'b0;
                  center_ok_ff <= 1'b1;
                  k_ff         <= '0;
                  phase_ff     <= (req_operation == OP_RADIUS) ? PH_RAD : PH_QX;
                  status_ff    <= ST_OK;
                  case (req_operation)
                     OP_CLEAR: begin
                        count_ff <= '0;
                        state_ff <= S_DONE;
                     end
                     OP_LOAD: begin
                        if (count_ff < COUNT_BITS'(LEAF_POINTS)) begin
                           count_ff <= count_ff + 1'b1;
                        end else begin
                           status_ff <= ST_FULL;
                        end
                        state_ff <= S_DONE;
                     end
                     OP_NEAREST, OP_EXCLUDE, OP_RADIUS: begin
                        state_ff <= S_ISSUE;
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_ISSUE: begin
               phase_ff <= phase_in;
               k_ff     <= k_in;
               if (scan_end) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               // wait for the last distances to leave the unit
               if (!unit_busy) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
                  if (is_search && !found_ff) begin
                     rsp_status_ff <= ST_NONE;
                     rsp_index_ff  <= '0;
                     rsp_dist_ff   <= '0;
                  end else if (is_search) begin
                     rsp_status_ff <= ST_OK;
                     rsp_index_ff  <= best_tag_ff;
                     rsp_dist_ff   <= best_dist_ff;
                  end else begin
                     rsp_status_ff <= status_ff;
                     rsp_index_ff  <= '0;
                     rsp_dist_ff   <= '0;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_nearest_index   = rsp_index_ff;
   assign rsp_nearest_dist_sq = rsp_dist_ff;

endmodule

`default_nettype wire
